// File: hdl/hrhs_pkg.sv
// Shared types and character constants for the HTTP response header scanner.
// No dependencies; compiled first.
package hrhs_pkg;

  // Characters the scanner reacts to
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_D0  = 8'h30;
  localparam logic [7:0] CH_D9  = 8'h39;

  localparam logic [15:0] STATUS_MAX = 16'hFFFF;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

  // Payload of one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } req_t;

  // Payload of one result
  typedef struct packed {
    logic [15:0] status_code;
    logic        header_end;
    logic        is_body;
    logic [7:0]  body_data;
    logic [31:0] body_count;
  } res_t;

endpackage

// File: hdl/hrhs_stream_if.sv
// Valid/ready channel carrying one payload of a chosen type.
// Depends on nothing; payload types come from hrhs_pkg at instantiation.
interface hrhs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/hrhs_core.sv
// Scanner state machine: protocol token, status digits, header end search, body count.
// Depends on hrhs_pkg.
module hrhs_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  hrhs_pkg::req_t req,
  output hrhs_pkg::res_t res
);

  typedef enum logic [3:0] {
    S_PROTOCOL   = 4'd0,
    S_WHITESPACE = 4'd1,
    S_STATUS     = 4'd2,
    S_BOL        = 4'd3,
    S_TEXT       = 4'd4,
    S_LF         = 4'd5,
    S_CR         = 4'd6,
    S_CRLF       = 4'd7,
    S_CRLFCR     = 4'd8,
    S_BODY       = 4'd9
  } state_t;

  state_t      state, state_next, state_cur;
  logic [15:0] accum, accum_next, accum_cur;
  logic [31:0] count, count_next, count_cur;
  logic [7:0]  c;
  logic        digit;
  logic        is_line_end;
  logic [19:0] acc_wide;
  logic [15:0] acc_sat;
  logic        end_hit;
  logic        body;

  // Next state after an ordinary or line-end byte in header states
  function automatic state_t line_next(input logic [7:0] ch);
    state_t s;
    if (ch == hrhs_pkg::CH_LF) begin
      s = S_LF;
    end else if (ch == hrhs_pkg::CH_CR) begin
      s = S_CR;
    end else begin
      s = S_TEXT;
    end
    return s;
  endfunction

  // Byte classification and status accumulation (acc*10 + digit, saturating)
  always_comb begin
    c           = req.data_byte;
    digit       = (c >= hrhs_pkg::CH_D0) && (c <= hrhs_pkg::CH_D9);
    is_line_end = (c == hrhs_pkg::CH_LF) || (c == hrhs_pkg::CH_CR);
    state_cur   = req.restart ? S_PROTOCOL : state;
    accum_cur   = req.restart ? 16'd0 : accum;
    count_cur   = req.restart ? 32'd0 : count;
    acc_wide    = ({4'd0, accum_cur} << 3) + ({4'd0, accum_cur} << 1) + {16'd0, c[3:0]};
    acc_sat     = (acc_wide > {4'd0, hrhs_pkg::STATUS_MAX}) ? hrhs_pkg::STATUS_MAX
                                                            : acc_wide[15:0];
  end

  // Transition logic
  always_comb begin
    state_next = state_cur;
    accum_next = accum_cur;
    count_next = count_cur;
    end_hit    = 1'b0;
    body       = 1'b0;
    unique case (state_cur)
      S_WHITESPACE: begin
        if (digit) begin
          accum_next = {12'd0, c[3:0]};
          state_next = S_STATUS;
        end else begin
          state_next = line_next(c);
        end
      end
      S_STATUS: begin
        if (digit) begin
          accum_next = acc_sat;
        end else begin
          state_next = line_next(c);
        end
      end
      S_BOL: begin
        state_next = line_next(c);
      end
      S_TEXT: begin
        if (is_line_end) begin
          state_next = line_next(c);
        end
      end
      S_LF: begin
        if (c == hrhs_pkg::CH_LF) begin
          end_hit = 1'b1;
        end else begin
          state_next = line_next(c);
        end
      end
      S_CR: begin
        priority if (c == hrhs_pkg::CH_CR) begin
          end_hit = 1'b1;
        end else if (c == hrhs_pkg::CH_LF) begin
          state_next = S_CRLF;
        end else begin
          state_next = S_TEXT;
        end
      end
      S_CRLF: begin
        priority if (c == hrhs_pkg::CH_LF) begin
          end_hit = 1'b1;
        end else if (c == hrhs_pkg::CH_CR) begin
          state_next = S_CRLFCR;
        end else begin
          state_next = S_TEXT;
        end
      end
      S_CRLFCR: begin
        if (is_line_end) begin
          end_hit = 1'b1;
        end else begin
          state_next = S_TEXT;
        end
      end
      S_BODY: begin
        body = 1'b1;
        if (count_cur != hrhs_pkg::COUNT_MAX) begin
          count_next = count_cur + 32'd1;
        end
      end
      default: begin
        // protocol token and unused codes
        priority if ((c == hrhs_pkg::CH_SP) || (c == hrhs_pkg::CH_TAB)) begin
          state_next = S_WHITESPACE;
        end else if (is_line_end) begin
          state_next = line_next(c);
        end else begin
          state_next = S_PROTOCOL;
        end
      end
    endcase
    if (end_hit) begin
      state_next = S_BODY;
    end
  end

  // Result of the current byte
  always_comb begin
    res.status_code = accum_next;
    res.header_end  = end_hit;
    res.is_body     = body;
    res.body_data   = body ? c : 8'd0;
    res.body_count  = count_next;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PROTOCOL;
      accum <= 16'd0;
      count <= 32'd0;
    end else if (step) begin
      state <= state_next;
      accum <= accum_next;
      count <= count_next;
    end
  end

endmodule

// File: hdl/http_response_header_scanner_unit.sv
// HTTP response header scanner: stream handshake and result register.
// Depends on hrhs_pkg, hrhs_stream_if and hrhs_core.
//
// Use: bytes of an HTTP response enter on the stream channel, one per request,
// each with a restart flag that starts a new response at that byte. For every
// byte one result leaves on the result channel: the status code gathered so
// far, a flag on the byte that closes the header block, and for body bytes the
// byte itself with a running saturating body count.
// The result is registered and valid in the cycle after its byte is taken.
// Throughput: one byte per cycle unless the receiver stalls; the parser step
// is a single state transition between the parser and result registers.
// Reset (rst, synchronous) returns the parser to the protocol token state,
// clears status and body count and empties the result register.
// When the receiver stalls, the held result stays stable and no new byte is
// taken until it has been accepted; a byte is taken in the same cycle that
// the held result leaves.
module http_response_header_scanner_unit (
  input  logic         clk,
  input  logic         rst,
  hrhs_stream_if.sink   stream,
  hrhs_stream_if.source result
);

  hrhs_pkg::res_t res_step;
  hrhs_pkg::res_t res_hold;
  logic           res_valid;
  logic           take;

  assign stream.ready = !res_valid || result.ready;
  assign take         = stream.valid && stream.ready;

  hrhs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .req  (stream.payload),
    .res  (res_step)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_hold <= res_step;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_hold;

endmodule
